@@ rtl/core/range_mode_query_unit_defines.svh @@
// ----------------------------------------------------------------------------
// range_mode_query_unit_defines
// Assertion macros shared by the range mode query checker.
// ----------------------------------------------------------------------------
`ifndef RANGE_MODE_QUERY_UNIT_DEFINES_SVH
`define RANGE_MODE_QUERY_UNIT_DEFINES_SVH

// same-cycle implication, muted during reset
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// next-cycle implication, muted during reset
`define RMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

@@ rtl/core/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants of the range mode query unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ARRAY_DEPTH = 1024;
    localparam int VALUE_COUNT = 128;
    localparam int ADDR_W      = $clog2(ARRAY_DEPTH);
    localparam int CNT_AW      = $clog2(VALUE_COUNT);
    localparam int VAL_W       = 7;
    localparam int POS_W       = ADDR_W + 1;
    localparam int CNT_W       = 11;
    localparam int MODE_W      = 8;

    localparam logic [VAL_W-1:0]  LIMIT_RESET = 7'd100;
    localparam logic [MODE_W-1:0] NO_MODE     = 8'hFF;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_FETCH,
        ST_UPD,
        ST_SCAN,
        ST_LAST,
        ST_OUT
    } t_state;

endpackage

@@ rtl/core/rmq_in_if.sv @@
// ----------------------------------------------------------------------------
// rmq_in_if
// Input channel: load and query beats.
// ----------------------------------------------------------------------------
interface rmq_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [6:0] element_value;
    logic [9:0] left_index;
    logic [9:0] right_index;

    modport source (output valid, op, element_value, left_index, right_index, input ready);
    modport sink   (input valid, op, element_value, left_index, right_index, output ready);
endinterface

@@ rtl/core/rmq_out_if.sv @@
// ----------------------------------------------------------------------------
// rmq_out_if
// Output channel: one result beat per query.
// ----------------------------------------------------------------------------
interface rmq_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] mode_value;
    logic              range_error;

    modport source (output valid, mode_value, range_error, input ready);
    modport sink   (input valid, mode_value, range_error, output ready);
endinterface

@@ rtl/core/rmq_ram.sv @@
// ----------------------------------------------------------------------------
// rmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/rmq_cnt_mem.sv @@
// ----------------------------------------------------------------------------
// rmq_cnt_mem
// Per-value count store; entry valid bits make it read zero after reset.
// ----------------------------------------------------------------------------
module rmq_cnt_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [rmq_pkg::CNT_AW-1:0] i_waddr,
    input  logic [rmq_pkg::CNT_W-1:0]  i_wdata,
    input  logic [rmq_pkg::CNT_AW-1:0] i_raddr,
    output logic [rmq_pkg::CNT_W-1:0]  o_rdata
);
    import rmq_pkg::*;

    logic [CNT_W-1:0]       r_mem [VALUE_COUNT];
    logic [VALUE_COUNT-1:0] r_vld;
    logic [CNT_W-1:0]       r_rdata;
    logic                   r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;
endmodule

@@ rtl/core/range_mode_query_unit.sv @@
// A load writes the element store; a query moves the window ends one element
// at a time (plan, fetch, update per move), then scans the counts of values
// 1 to value_limit (none if it is 0); a bad window skips both steps.
// One item at a time; a query ending while the last result beat is held waits.
// Reset: synchronous, active low; counts read zero, window empty,
// value_limit 100, no elements loaded.
// ----------------------------------------------------------------------------
// range_mode_query_unit
// Sliding-window range mode over an element store and a count store.
// ----------------------------------------------------------------------------
module range_mode_query_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    rmq_in_if.sink      i_in,
    rmq_out_if.source   o_out
);
    import rmq_pkg::*;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_loaded, n_loaded;
    logic [POS_W-1:0]   r_wl, n_wl;
    logic [POS_W-1:0]   r_wr1, n_wr1;
    logic [POS_W-1:0]   r_lo, n_lo;
    logic [POS_W-1:0]   r_hi1, n_hi1;
    logic               r_dec, n_dec;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [CNT_AW-1:0]  r_idx, n_idx;
    logic [CNT_AW-1:0]  r_pidx, n_pidx;
    logic               r_pv, n_pv;
    logic [VAL_W-1:0]   r_limit;
    logic [CNT_W-1:0]   r_best_cnt, n_best_cnt;
    logic [MODE_W-1:0]  r_best_val, n_best_val;
    logic               r_err, n_err;
    logic               r_ov, n_ov;
    logic [MODE_W-1:0]  r_omode, n_omode;
    logic               r_oerr, n_oerr;

    logic               e_we;
    logic [ADDR_W-1:0]  e_waddr, e_raddr;
    logic [VAL_W-1:0]   e_wdata, e_rdata;
    logic               c_we;
    logic [CNT_AW-1:0]  c_waddr, c_raddr;
    logic [CNT_W-1:0]   c_wdata, c_rdata;
    logic [POS_W-1:0]   pos;

    rmq_ram #(.DEPTH(ARRAY_DEPTH), .WIDTH(VAL_W)) u_elem (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    rmq_cnt_mem u_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_loaded <= '0;
            r_wl     <= '0;
            r_wr1    <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
            r_limit  <= LIMIT_RESET;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_wl     <= n_wl;
            r_wr1    <= n_wr1;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi1      <= n_hi1;
        r_dec      <= n_dec;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_best_cnt <= n_best_cnt;
        r_best_val <= n_best_val;
        r_err      <= n_err;
        r_omode    <= n_omode;
        r_oerr     <= n_oerr;
    end

    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_wl       = r_wl;
        n_wr1      = r_wr1;
        n_lo       = r_lo;
        n_hi1      = r_hi1;
        n_dec      = r_dec;
        n_val      = r_val;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pv       = 1'b0;
        n_best_cnt = r_best_cnt;
        n_best_val = r_best_val;
        n_err      = r_err;
        n_ov       = r_ov;
        n_omode    = r_omode;
        n_oerr     = r_oerr;
        e_we       = 1'b0;
        e_waddr    = r_loaded[ADDR_W-1:0];
        e_wdata    = i_in.element_value;
        e_raddr    = '0;
        c_we       = 1'b0;
        c_waddr    = r_val;
        c_wdata    = r_dec ? (c_rdata - 1'b1) : (c_rdata + 1'b1);
        c_raddr    = r_idx;
        pos        = '0;
        i_in.ready = 1'b0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        if (r_pv && (c_rdata > r_best_cnt)) begin
            n_best_cnt = c_rdata;
            n_best_val = {1'b0, r_pidx};
        end

        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.op == OP_LOAD) begin
                        if (r_loaded < POS_W'(ARRAY_DEPTH)) begin
                            e_we     = 1'b1;
                            n_loaded = r_loaded + 1'b1;
                        end
                    end else begin
                        n_lo       = {1'b0, i_in.left_index};
                        n_hi1      = {1'b0, i_in.right_index} + 1'b1;
                        n_best_cnt = '0;
                        n_best_val = NO_MODE;
                        if ((i_in.left_index > i_in.right_index) ||
                            ({1'b0, i_in.right_index} >= r_loaded)) begin
                            n_err   = 1'b1;
                            n_state = ST_OUT;
                        end else begin
                            n_err   = 1'b0;
                            n_state = ST_PLAN;
                        end
                    end
                end
            end
            ST_PLAN: begin
                if (r_wr1 < r_hi1) begin
                    pos     = r_wr1;
                    n_dec   = 1'b0;
                    n_wr1   = r_wr1 + 1'b1;
                    n_state = ST_FETCH;
                end else if (r_wr1 > r_hi1) begin
                    pos     = r_wr1 - 1'b1;
                    n_dec   = 1'b1;
                    n_wr1   = r_wr1 - 1'b1;
                    n_state = ST_FETCH;
                end else if (r_wl < r_lo) begin
                    pos     = r_wl;
                    n_dec   = 1'b1;
                    n_wl    = r_wl + 1'b1;
                    n_state = ST_FETCH;
                end else if (r_wl > r_lo) begin
                    pos     = r_wl - 1'b1;
                    n_dec   = 1'b0;
                    n_wl    = r_wl - 1'b1;
                    n_state = ST_FETCH;
                end else begin
                    n_idx   = CNT_AW'(1);
                    n_state = (r_limit == '0) ? ST_OUT : ST_SCAN;
                end
                e_raddr = pos[ADDR_W-1:0];
            end
            ST_FETCH: begin
                n_val   = e_rdata;
                c_raddr = e_rdata;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                c_we    = 1'b1;
                n_state = ST_PLAN;
            end
            ST_SCAN: begin
                c_raddr = r_idx;
                n_pv    = 1'b1;
                n_pidx  = r_idx;
                if (r_idx == r_limit) begin
                    n_state = ST_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_LAST: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_omode = n_best_val;
                    n_oerr  = r_err;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out.valid       = r_ov;
    assign o_out.mode_value  = r_omode;
    assign o_out.range_error = r_oerr;
endmodule

@@ rtl/core/rmq_checker.sv @@
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the range mode query unit result channel.
// ----------------------------------------------------------------------------
`include "range_mode_query_unit_defines.svh"

module rmq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_mode_value,
    input logic       i_range_error
);
    `RMQ_ASSERT_NXT(a_hold_beat, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `RMQ_ASSERT_IMP(a_err_no_mode, i_clk, i_rst_n, i_out_valid && i_range_error, i_mode_value == 8'hFF)
    `RMQ_ASSERT_IMP(a_mode_range, i_clk, i_rst_n, i_out_valid, (i_mode_value == 8'hFF) || !i_mode_value[7])
endmodule

bind range_mode_query_unit rmq_checker u_rmq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_mode_value  (o_out.mode_value),
    .i_range_error (o_out.range_error)
);
